FILE: rtl/core/lbp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lbp_pkg
// Shared constants for the LBP pixel operator: field widths, configuration
// register indexes and reset frame size.
// ----------------------------------------------------------------------------
package lbp_pkg;

    // pixel and code widths
    localparam int PIX_W  = 8;
    localparam int CODE_W = 8;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;
    localparam int IMG_W_BITS = 11;
    localparam int IMG_H_BITS = 13;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_IMAGE_WIDTH  = 2'd0,
        REG_IMAGE_HEIGHT = 2'd1
    } t_cfg_reg;

    // frame size after reset
    localparam int RST_IMAGE_WIDTH  = 640;
    localparam int RST_IMAGE_HEIGHT = 480;

    // smallest frame the window can work on
    localparam int MIN_SIZE = 3;

endpackage

FILE: rtl/core/lbp_line_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lbp_line_mem
// One-row line store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module lbp_line_mem #(
    parameter int DEPTH  = 1024,
    parameter int ADDR_W = 10,
    parameter int DATA_W = 8
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [DATA_W-1:0] i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read port, registered read data
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/core/lbp_out_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lbp_out_fifo
// Result buffer: takes up to two requests per cycle, hands out one while not stalled.
// ----------------------------------------------------------------------------
module lbp_out_fifo #(
    parameter int DATA_W = 31
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push0,
    input  logic [DATA_W-1:0] i_data0,
    input  logic              i_push1,   // only together with i_push0
    input  logic [DATA_W-1:0] i_data1,
    output logic [3:0]        o_count,
    output logic              o_valid,
    output logic [DATA_W-1:0] o_data,
    input  logic              i_stall
);

    localparam int DEPTH = 8;

    logic [DATA_W-1:0] r_buf [DEPTH];
    logic [2:0]        r_wr_ptr, n_wr_ptr;
    logic [2:0]        r_rd_ptr, n_rd_ptr;
    logic [3:0]        r_count,  n_count;
    logic              pop;
    logic [2:0]        wr_ptr_p1;

    assign pop       = (r_count != 4'd0) && !i_stall;
    assign wr_ptr_p1 = r_wr_ptr + 3'd1;

    // pointer and fill bookkeeping
    always_comb begin
        n_wr_ptr = r_wr_ptr + {1'b0, i_push0 && i_push1, i_push0 && !i_push1};
        n_rd_ptr = r_rd_ptr + {2'b00, pop};
        n_count  = r_count + {2'b00, i_push0 && i_push1, i_push0 && !i_push1}
                   - {3'b000, pop};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push0) begin
            r_buf[r_wr_ptr] <= i_data0;
        end
        if (i_push0 && i_push1) begin
            r_buf[wr_ptr_p1] <= i_data1;
        end
    end

    assign o_count = r_count;
    assign o_valid = (r_count != 4'd0);
    assign o_data  = r_buf[r_rd_ptr];

endmodule

FILE: rtl/core/lbp_pixel_operator_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lbp_pixel_operator_top
// Streaming 8-neighbor, radius-1 local binary pattern over a raster pixel
// stream, with coordinate-tagged results.
// ----------------------------------------------------------------------------
// Pixels are taken one per clock while input stall is low. Each pixel reads
// the two line stores at its column in the cycle it is accepted. In the next
// cycle the code is formed from the read data, the 3x2 column window and the
// pixel, and the line stores are written back at the same column. A pixel
// yields zero, one or two results (the interior code finished at (x-1,y-1),
// then a zero for a border pixel), pushed from the compute stage into an
// 8-entry result buffer that drains one per clock while output stall is low.
// Pixels that give one result or none keep the rate at one pixel per clock.
// Pixels that give two results (the last column of rows two and up, and every
// pixel from column two on in the last row) add one extra result each. The
// buffer absorbs these until input stall rises, which happens once the
// buffered count plus two for a pixel in flight exceeds six. Over a long last
// row the input is then paced by the buffer draining both results of each
// pixel. Input stall also rises when the output side holds results back.
// Writing either size register restarts the frame at (0,0). Line-store
// contents are kept and need no clearing.
// ----------------------------------------------------------------------------
module lbp_pixel_operator_top #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // configuration
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [lbp_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [lbp_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    // pixel input
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [lbp_pkg::PIX_W-1:0]           i_pixel,
    // result output
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic [lbp_pkg::CODE_W-1:0]          o_code,
    output logic [$clog2(MAX_WIDTH)-1:0]        o_out_x,
    output logic [$clog2(MAX_HEIGHT)-1:0]       o_out_y,
    output logic                                o_last_of_item
);

    localparam int XW    = $clog2(MAX_WIDTH);
    localparam int YW    = $clog2(MAX_HEIGHT);
    localparam int PW    = lbp_pkg::PIX_W;
    localparam int CW    = lbp_pkg::CODE_W;
    localparam int RES_W = CW + XW + YW + 1;
    localparam int RST_W = (lbp_pkg::RST_IMAGE_WIDTH > MAX_WIDTH) ?
                           MAX_WIDTH : lbp_pkg::RST_IMAGE_WIDTH;
    localparam int RST_H = (lbp_pkg::RST_IMAGE_HEIGHT > MAX_HEIGHT) ?
                           MAX_HEIGHT : lbp_pkg::RST_IMAGE_HEIGHT;

    // ------------------------------------------------------------------
    // configuration: keep last column / last row indexes, clamped
    // ------------------------------------------------------------------
    logic          r_cfg_ready;
    logic [XW-1:0] r_last_x, n_last_x;
    logic [YW-1:0] r_last_y, n_last_y;
    logic          cfg_wr;
    logic          cfg_hit;
    int            cfg_w;
    int            cfg_h;

    assign cfg_wr = i_cfg_valid && r_cfg_ready;

    always_comb begin
        cfg_w = int'(i_cfg_data[lbp_pkg::IMG_W_BITS-1:0]);
        cfg_h = int'(i_cfg_data[lbp_pkg::IMG_H_BITS-1:0]);
        if (cfg_w < lbp_pkg::MIN_SIZE) cfg_w = lbp_pkg::MIN_SIZE;
        if (cfg_w > MAX_WIDTH)         cfg_w = MAX_WIDTH;
        if (cfg_h < lbp_pkg::MIN_SIZE) cfg_h = lbp_pkg::MIN_SIZE;
        if (cfg_h > MAX_HEIGHT)        cfg_h = MAX_HEIGHT;
        n_last_x = r_last_x;
        n_last_y = r_last_y;
        cfg_hit  = 1'b0;
        if (cfg_wr) begin
            unique case (i_cfg_index)
                lbp_pkg::REG_IMAGE_WIDTH: begin
                    n_last_x = XW'(cfg_w - 1);
                    cfg_hit  = 1'b1;
                end
                lbp_pkg::REG_IMAGE_HEIGHT: begin
                    n_last_y = YW'(cfg_h - 1);
                    cfg_hit  = 1'b1;
                end
                default: begin
                    cfg_hit = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_ready <= 1'b0;
            r_last_x    <= XW'(RST_W - 1);
            r_last_y    <= YW'(RST_H - 1);
        end else begin
            r_cfg_ready <= 1'b1;
            r_last_x    <= n_last_x;
            r_last_y    <= n_last_y;
        end
    end

    assign o_cfg_ready = r_cfg_ready;

    // ------------------------------------------------------------------
    // raster position counters
    // ------------------------------------------------------------------
    logic          in_acc;
    logic [XW-1:0] r_col, n_col;
    logic [YW-1:0] r_row, n_row;

    assign in_acc = i_in_valid && !o_in_stall;

    always_comb begin
        n_col = r_col;
        n_row = r_row;
        priority if (cfg_hit) begin
            n_col = '0;
            n_row = '0;
        end else if (in_acc) begin
            if (r_col == r_last_x) begin
                n_col = '0;
                n_row = (r_row == r_last_y) ? '0 : r_row + YW'(1);
            end else begin
                n_col = r_col + XW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    // ------------------------------------------------------------------
    // accept stage: issue line-store reads, capture pixel and flags
    // ------------------------------------------------------------------
    logic          r_v;
    logic [PW-1:0] r_pix;
    logic [XW-1:0] r_x;
    logic [YW-1:0] r_y;
    logic          r_has_code;
    logic          r_border;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else begin
            r_v <= in_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_pix      <= i_pixel;
            r_x        <= r_col;
            r_y        <= r_row;
            r_has_code <= (r_col >= XW'(2)) && (r_row >= YW'(2));
            r_border   <= (r_col == '0) || (r_row == '0) ||
                          (r_col == r_last_x) || (r_row == r_last_y);
        end
    end

    // line stores: older holds row y-2, newer holds row y-1.
    // Consecutive pixels hit different columns unless a size-register write
    // restarts the frame, so a write-back otherwise never meets a read of the same entry.
    logic [PW-1:0] top_px;
    logic [PW-1:0] mid_px;

    lbp_line_mem #(
        .DEPTH  (MAX_WIDTH),
        .ADDR_W (XW),
        .DATA_W (PW)
    ) u_older_mem (
        .i_clk   (i_clk),
        .i_we    (r_v),
        .i_waddr (r_x),
        .i_wdata (mid_px),
        .i_re    (in_acc),
        .i_raddr (r_col),
        .o_rdata (top_px)
    );

    lbp_line_mem #(
        .DEPTH  (MAX_WIDTH),
        .ADDR_W (XW),
        .DATA_W (PW)
    ) u_newer_mem (
        .i_clk   (i_clk),
        .i_we    (r_v),
        .i_waddr (r_x),
        .i_wdata (r_pix),
        .i_re    (in_acc),
        .i_raddr (r_col),
        .o_rdata (mid_px)
    );

    // ------------------------------------------------------------------
    // compute stage: window [0..2] column x-2, [3..5] column x-1
    // ------------------------------------------------------------------
    logic [PW-1:0] r_win [6];
    logic [PW-1:0] nb [8];
    logic [CW-1:0] code;

    always_comb begin
        nb[0] = mid_px;
        nb[1] = top_px;
        nb[2] = r_win[3];
        nb[3] = r_win[0];
        nb[4] = r_win[1];
        nb[5] = r_win[2];
        nb[6] = r_win[5];
        nb[7] = r_pix;
        for (int i = 0; i < 8; i++) begin
            code[7-i] = (nb[i] >= r_win[4]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 6; i++) begin
                r_win[i] <= '0;
            end
        end else if (r_v) begin
            r_win[0] <= r_win[3];
            r_win[1] <= r_win[4];
            r_win[2] <= r_win[5];
            r_win[3] <= top_px;
            r_win[4] <= mid_px;
            r_win[5] <= r_pix;
        end
    end

    // result requests toward the buffer
    logic             push0;
    logic             push1;
    logic [RES_W-1:0] res0;
    logic [RES_W-1:0] res1;
    logic [3:0]       fifo_count;
    logic [RES_W-1:0] out_data;

    always_comb begin
        push0 = r_v && (r_has_code || r_border);
        push1 = r_v && r_has_code && r_border;
        res1  = {CW'(0), r_x, r_y, 1'b1};
        if (r_has_code) begin
            res0 = {code, r_x - XW'(1), r_y - YW'(1), !r_border};
        end else begin
            res0 = res1;
        end
    end

    lbp_out_fifo #(
        .DATA_W (RES_W)
    ) u_out_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push0 (push0),
        .i_data0 (res0),
        .i_push1 (push1),
        .i_data1 (res1),
        .o_count (fifo_count),
        .o_valid (o_out_valid),
        .o_data  (out_data),
        .i_stall (i_out_stall)
    );

    // room for the worst case of the item in flight and the next one
    assign o_in_stall = ({1'b0, fifo_count} + {3'b000, r_v, 1'b0}) > 5'd6;

    assign o_code         = out_data[RES_W-1 -: CW];
    assign o_out_x        = out_data[XW+YW : YW+1];
    assign o_out_y        = out_data[YW : 1];
    assign o_last_of_item = out_data[0];

endmodule

FILE: rtl/core/lbp_pixel_operator_chk.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lbp_pixel_operator_chk
// Port-level checks on the LBP pixel operator, bound to the top level.
// ----------------------------------------------------------------------------
module lbp_pixel_operator_chk #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_valid,
    input  logic                                o_cfg_ready,
    input  logic [lbp_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [lbp_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    input  logic                                i_in_valid,
    input  logic                                o_in_stall,
    input  logic [lbp_pkg::PIX_W-1:0]           i_pixel,
    input  logic                                o_out_valid,
    input  logic                                i_out_stall,
    input  logic [lbp_pkg::CODE_W-1:0]          o_code,
    input  logic [$clog2(MAX_WIDTH)-1:0]        o_out_x,
    input  logic [$clog2(MAX_HEIGHT)-1:0]       o_out_y,
    input  logic                                o_last_of_item
);

    // a held-back result keeps its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=>
            (o_out_valid && $stable(o_code) && $stable(o_out_x) &&
             $stable(o_out_y) && $stable(o_last_of_item)))
        else $error("result changed while stalled");

    // nothing comes out right after reset
    a_out_reset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$past(i_rst_n) |-> !o_out_valid)
        else $error("result presented right after reset");

    // a non-final result is an interior code, never in row or column zero
    a_interior_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_last_of_item) |-> (o_out_x != '0 && o_out_y != '0))
        else $error("interior code tagged with border coordinates");

    // column zero is always border, so its code is zero
    a_border_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_x == '0) |-> (o_code == '0 && o_last_of_item))
        else $error("nonzero code in column zero");

    // with nothing buffered and nothing in flight, input is never stalled
    a_no_idle_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_out_valid && !$past(i_in_valid && !o_in_stall)) |-> !o_in_stall)
        else $error("input stalled while empty");

endmodule

bind lbp_pixel_operator_top lbp_pixel_operator_chk #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
) u_lbp_chk (.*);
